// ===== hw/rtl/slist_pkg.sv =====
// ----------------------------------------------------------------------------
// slist_pkg
// Shared widths, defaults, op codes and result codes for the sorted list block.
// ----------------------------------------------------------------------------
package slist_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned COUNT_W       = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ===== hw/rtl/sorted_list_insert_remove_max.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_max
// Sorted store of signed values used as a remove-largest priority queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (in_valid/in_ready) carry op and value. An insert
//   places value after every stored value less than or equal to it; a remove
//   takes out the largest stored value. Every input transaction produces one
//   output transaction (out_valid/out_ready) with status, removed_value and
//   the count of stored values after the operation.
//   The values live in one single-port-write, single-port-read memory with a
//   registered read. An insert walks down from the top of the list, moving
//   one larger entry up per cycle until it meets a smaller or equal entry
//   or the bottom, then writes the new value. A remove reads the top entry.
//   An insert into an empty store, a dropped insert or a remove on an
//   empty store goes straight from idle to the result state. One item is
//   in work at a time; the next is accepted once the block is back in idle.
//   The result register holds a finished result while the receiver stalls;
//   the block still accepts and works on the next item, and waits to hand
//   over that result until the register is free.
//   Reset empties the list at once; the memory contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_max #(
  parameter int unsigned DEPTH = slist_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 op,
  input  logic signed [slist_pkg::VALUE_W-1:0] value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           status,
  output logic signed [slist_pkg::VALUE_W-1:0] removed_value,
  output logic [slist_pkg::COUNT_W-1:0]        count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = slist_pkg::VALUE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PUT,
    S_REM,
    S_FIN
  } state_t;

  state_t                state;
  logic [CW-1:0]         fill;
  logic [AW-1:0]         idx;
  logic signed [VW-1:0]  val_reg;
  slist_pkg::status_t    res_status;
  logic signed [VW-1:0]  res_value;

  logic signed [VW-1:0]  mem [DEPTH];
  logic signed [VW-1:0]  rd_data;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic signed [VW-1:0]  mem_wdata;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;

  logic                  accept;
  logic                  out_free;
  logic                  fin_load;
  logic                  is_full;
  logic                  is_empty;
  logic [AW-1:0]         top_addr;
  logic [CW+slist_pkg::COUNT_W-1:0] fill_ext;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign fin_load = (state == S_FIN) && out_free;
  assign is_full  = (fill == CW'(DEPTH));
  assign is_empty = (fill == '0);
  assign top_addr = AW'(fill - CW'(1));
  assign fill_ext = {{slist_pkg::COUNT_W{1'b0}}, fill};

  // Memory port control. While scanning, the entry read last cycle sits at
  // idx-1; a larger one moves up to idx and the read moves one step down.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = value;
    rd_en     = 1'b0;
    rd_addr   = top_addr;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == slist_pkg::OP_INSERT) begin
            if (is_empty) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = value;
            end else if (!is_full) begin
              rd_en = 1'b1;
            end
          end else if (!is_empty) begin
            rd_en = 1'b1;
          end
        end
      end
      S_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        if (rd_data > val_reg) begin
          mem_wdata = rd_data;
          if (idx != AW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = idx - AW'(2);
          end
        end else begin
          mem_wdata = val_reg;
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = val_reg;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            val_reg   <= value;
            idx       <= fill[AW-1:0];
            res_value <= '0;
            if (op == slist_pkg::OP_INSERT) begin
              if (is_full) begin
                res_status <= slist_pkg::ST_FULL;
                state      <= S_FIN;
              end else if (is_empty) begin
                res_status <= slist_pkg::ST_DONE;
                fill       <= fill + CW'(1);
                state      <= S_FIN;
              end else begin
                res_status <= slist_pkg::ST_DONE;
                state      <= S_SCAN;
              end
            end else begin
              if (is_empty) begin
                res_status <= slist_pkg::ST_EMPTY;
                state      <= S_FIN;
              end else begin
                res_status <= slist_pkg::ST_DONE;
                fill       <= fill - CW'(1);
                state      <= S_REM;
              end
            end
          end
        end
        S_SCAN: begin
          if (rd_data > val_reg) begin
            idx <= idx - AW'(1);
            if (idx == AW'(1)) begin
              state <= S_PUT;
            end
          end else begin
            fill  <= fill + CW'(1);
            state <= S_FIN;
          end
        end
        S_PUT: begin
          fill  <= fill + CW'(1);
          state <= S_FIN;
        end
        S_REM: begin
          res_value <= rd_data;
          state     <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            status        <= res_status;
            removed_value <= res_value;
            count         <= fill_ext[slist_pkg::COUNT_W-1:0];
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count exceeds the list depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted transaction did not leave idle");

  a_full_code: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res_status == slist_pkg::ST_FULL) |-> is_full)
    else $error("full status reported on a list that is not full");

  a_empty_code: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res_status == slist_pkg::ST_EMPTY) |-> is_empty)
    else $error("empty status reported on a list that is not empty");

  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> idx != '0)
    else $error("scan reached the bottom entry without placing the value");

endmodule
